FILE: hdl/blle_pkg.sv
// Package: shared constants, types and codes for the linked list engine.
`timescale 1ns / 1ps
package blle_pkg;
  localparam int Capacity = 16;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int ValW = 32;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0, FN_PUSH_HEAD = 3'd1, FN_INS_AFTER = 3'd2,
    FN_DEL_HEAD = 3'd3, FN_DEL_TAIL = 3'd4, FN_DEL_POS = 3'd5,
    FN_NOP6 = 3'd6, FN_NOP7 = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_RD, S_CHK, S_INS_WR, S_INS_LINK, S_DHEAD, S_DHEAD2,
    S_DAFT, S_DAFT2, S_DAFT3, S_DONE, S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request
    logic rd_cur;     // read value/link at cur
    logic step;       // cur <= link, idx++
    logic ins_wr;     // write new node
    logic ins_link;   // patch predecessor / head / tail
    logic dh_rd;      // read head
    logic dh_fin;     // finish head removal
    logic da_rd;      // read victim (link of cur)
    logic da_fin;     // finish removal after cur
    logic set_stat;
    status_t stat;
    logic finish;     // load output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    func_t func;
    logic full;
    logic empty;
    logic one;
    logic pos_bad;
    logic pos_zero;
    logic match;      // value at cur equals key
    logic at_end;     // walk reached last allowed node
    logic at_target;  // walk reached predecessor
  } stat_t;
endpackage

FILE: hdl/bounded_linked_list_engine_unit.sv
// Top level of the bounded singly linked list engine.
// Usage: one word on the input channel (func, value, key, position) requests one
// list operation; exactly one word comes back (status, removed_value, length).
// Both channels are valid/stall; a word moves when valid is high and stall low.
// The engine works on one word at a time: in_stall is high from acceptance until
// the result is loaded into the output register; the next word may be taken in
// the cycle after that. Words answered by status alone go straight to the result;
// inserts at head or tail and head deletes need no walk. Key searches and tail or
// positional deletes walk the links one node at a time (store read then compare);
// the registered read of the value and link stores sets the pace of this walk.
// Reset (rst, synchronous) empties the list and drops any pending result; the
// value and link stores need no clearing.
// If the receiver stalls, the result holds; the engine may take and work on the
// next word, then waits until the output register is free.
`timescale 1ns / 1ps
module bounded_linked_list_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] value,
  input  logic signed [31:0] key,
  input  logic [3:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic [4:0]         length
);
  blle_pkg::cmd_t  cmd;
  blle_pkg::stat_t st;

  blle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid), .st(st), .cmd(cmd));

  blle_dp u_dp (
    .clk(clk), .rst(rst), .func(func), .value(value), .key(key),
    .position(position), .cmd(cmd), .st(st), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .removed_value(removed_value),
    .length(length));
endmodule

FILE: hdl/blle_ram.sv
// Generic single-write, registered-read RAM.
`timescale 1ns / 1ps
module blle_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/blle_ctrl.sv
// Controller state machine for the linked list engine.
`timescale 1ns / 1ps
module blle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_busy,
  input  blle_pkg::stat_t  st,
  output blle_pkg::cmd_t   cmd
);
  blle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      blle_pkg::S_IDLE: if (in_valid) state_next = blle_pkg::S_DECIDE;
      blle_pkg::S_DECIDE: begin
        unique case (st.func)
          blle_pkg::FN_APPEND, blle_pkg::FN_PUSH_HEAD:
            state_next = st.full ? blle_pkg::S_DONE : blle_pkg::S_INS_WR;
          blle_pkg::FN_INS_AFTER:
            state_next = (st.full || st.empty) ? blle_pkg::S_DONE : blle_pkg::S_RD;
          blle_pkg::FN_DEL_HEAD:
            state_next = st.empty ? blle_pkg::S_DONE : blle_pkg::S_DHEAD;
          blle_pkg::FN_DEL_TAIL:
            state_next = st.empty ? blle_pkg::S_DONE :
                         st.one ? blle_pkg::S_DHEAD : blle_pkg::S_RD;
          blle_pkg::FN_DEL_POS:
            state_next = (st.empty || st.pos_bad) ? blle_pkg::S_DONE :
                         st.pos_zero ? blle_pkg::S_DHEAD : blle_pkg::S_RD;
          default: state_next = blle_pkg::S_DONE;
        endcase
      end
      blle_pkg::S_RD: state_next = blle_pkg::S_CHK;
      blle_pkg::S_CHK: begin
        if (st.func == blle_pkg::FN_INS_AFTER) begin
          if (st.match) state_next = blle_pkg::S_INS_WR;
          else if (st.at_end) state_next = blle_pkg::S_DONE;
          else state_next = blle_pkg::S_RD;
        end else begin
          state_next = st.at_target ? blle_pkg::S_DAFT : blle_pkg::S_RD;
        end
      end
      blle_pkg::S_INS_WR: state_next = blle_pkg::S_INS_LINK;
      blle_pkg::S_INS_LINK: state_next = blle_pkg::S_DONE;
      blle_pkg::S_DHEAD: state_next = blle_pkg::S_DHEAD2;
      blle_pkg::S_DHEAD2: state_next = blle_pkg::S_DONE;
      blle_pkg::S_DAFT: state_next = blle_pkg::S_DAFT2;
      blle_pkg::S_DAFT2: state_next = blle_pkg::S_DAFT3;
      blle_pkg::S_DAFT3: state_next = blle_pkg::S_DONE;
      blle_pkg::S_DONE: if (!out_busy) state_next = blle_pkg::S_IDLE;
      default: state_next = blle_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.stat = blle_pkg::ST_OK;
    in_stall = (state != blle_pkg::S_IDLE);
    unique case (state)
      blle_pkg::S_IDLE: cmd.load = in_valid;
      blle_pkg::S_DECIDE: begin
        cmd.set_stat = 1'b1;
        cmd.rd_cur = 1'b1;
        if ((st.func == blle_pkg::FN_APPEND || st.func == blle_pkg::FN_PUSH_HEAD ||
             st.func == blle_pkg::FN_INS_AFTER) && st.full)
          cmd.stat = blle_pkg::ST_FULL;
        else if ((st.func == blle_pkg::FN_INS_AFTER || st.func == blle_pkg::FN_DEL_HEAD ||
                  st.func == blle_pkg::FN_DEL_TAIL || st.func == blle_pkg::FN_DEL_POS) &&
                 st.empty)
          cmd.stat = blle_pkg::ST_EMPTY;
        else if (st.func == blle_pkg::FN_DEL_POS && st.pos_bad)
          cmd.stat = blle_pkg::ST_NOTFOUND;
        cmd.dh_rd = 1'b1;
      end
      blle_pkg::S_RD: cmd.rd_cur = 1'b1;
      blle_pkg::S_CHK: begin
        if (st.func == blle_pkg::FN_INS_AFTER) begin
          if (!st.match && st.at_end) begin
            cmd.set_stat = 1'b1;
            cmd.stat = blle_pkg::ST_NOTFOUND;
          end else if (!st.match) cmd.step = 1'b1;
        end else if (!st.at_target) cmd.step = 1'b1;
      end
      blle_pkg::S_INS_WR: cmd.ins_wr = 1'b1;
      blle_pkg::S_INS_LINK: cmd.ins_link = 1'b1;
      blle_pkg::S_DHEAD: cmd.dh_rd = 1'b1;
      blle_pkg::S_DHEAD2: cmd.dh_fin = 1'b1;
      blle_pkg::S_DAFT: cmd.rd_cur = 1'b1;
      blle_pkg::S_DAFT2: cmd.da_rd = 1'b1;
      blle_pkg::S_DAFT3: cmd.da_fin = 1'b1;
      blle_pkg::S_DONE: cmd.finish = !out_busy;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == blle_pkg::S_DECIDE) else $error("load did not start work");
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == blle_pkg::S_IDLE) else $error("finish did not end work");
  assert property (@(posedge clk) disable iff (rst)
    state != blle_pkg::S_IDLE |-> in_stall) else $error("input open while busy");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ins_wr, cmd.ins_link, cmd.dh_fin, cmd.da_fin}))
    else $error("overlapping store updates");
endmodule

FILE: hdl/blle_dp.sv
// Datapath: value and link stores, free map, list pointers and result register.
`timescale 1ns / 1ps
module blle_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [2:0]             func,
  input  logic signed [31:0]     value,
  input  logic signed [31:0]     key,
  input  logic [3:0]             position,
  input  blle_pkg::cmd_t         cmd,
  output blle_pkg::stat_t        st,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic signed [31:0]     removed_value,
  output logic [4:0]             length
);
  localparam int SW = blle_pkg::SlotW;
  localparam int CW = blle_pkg::CountW;

  blle_pkg::func_t         r_func;
  logic [31:0]             r_value, r_key;
  logic [3:0]              r_pos;
  logic [blle_pkg::Capacity-1:0] free_map;
  logic [SW-1:0]           head, tail, cur, newslot;
  logic [CW-1:0]           count, idx;
  blle_pkg::status_t       r_stat;
  logic [31:0]             r_removed;
  logic [SW-1:0]           victim;

  // store ports
  logic           v_we, l_we;
  logic [SW-1:0]  v_wa, l_wa, v_ra, l_ra;
  logic [31:0]    v_wd, v_rd;
  logic [SW-1:0]  l_wd, l_rd;

  blle_ram #(.Width(32), .Depth(blle_pkg::Capacity)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  blle_ram #(.Width(SW), .Depth(blle_pkg::Capacity)) u_lnk (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));

  // lowest free slot
  always_comb begin
    newslot = '0;
    for (int i = blle_pkg::Capacity - 1; i >= 0; i--)
      if (free_map[i]) newslot = SW'(i);
  end

  // walk target: index of predecessor for deletes
  logic [CW-1:0] target;
  always_comb begin
    if (r_func == blle_pkg::FN_DEL_TAIL) target = count - CW'(2);
    else target = CW'(r_pos) - CW'(1);
  end

  assign st.func = r_func;
  assign st.full = (count == CW'(blle_pkg::Capacity));
  assign st.empty = (count == '0);
  assign st.one = (count == CW'(1));
  assign st.pos_bad = (CW'(r_pos) >= count);
  assign st.pos_zero = (r_pos == '0);
  assign st.match = (v_rd == r_key);
  assign st.at_end = (idx == count - CW'(1));
  assign st.at_target = (idx == target);

  always_comb begin
    v_we = 1'b0; v_wa = newslot; v_wd = r_value;
    l_we = 1'b0; l_wa = newslot; l_wd = '0;
    v_ra = cur; l_ra = cur;
    if (cmd.dh_rd) begin
      v_ra = head; l_ra = head;
    end
    if (cmd.rd_cur) begin
      v_ra = cur; l_ra = cur;
    end
    if (cmd.da_rd) begin
      v_ra = l_rd; l_ra = l_rd;
    end
    if (cmd.ins_wr) begin
      v_we = 1'b1; l_we = 1'b1;
      unique case (r_func)
        blle_pkg::FN_APPEND: l_wd = '0;
        blle_pkg::FN_PUSH_HEAD: l_wd = (count == '0) ? '0 : head;
        default: l_wd = (cur == tail) ? '0 : l_rd;
      endcase
    end
    if (cmd.ins_link) begin
      // point predecessor at the new node (held in victim)
      l_wa = (r_func == blle_pkg::FN_APPEND) ? tail : cur;
      l_wd = victim;
      l_we = (r_func == blle_pkg::FN_INS_AFTER) ||
             (r_func == blle_pkg::FN_APPEND && count != '0);
    end
    if (cmd.da_fin) begin
      l_we = 1'b1; l_wa = cur; l_wd = l_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      head <= '0;
      tail <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.finish) out_valid <= 1'b1;
      if (cmd.ins_link) begin
        // slot is claimed together with the count so the two stay in step
        free_map[victim] <= 1'b0;
        count <= count + CW'(1);
        unique case (r_func)
          blle_pkg::FN_APPEND: begin
            tail <= victim;
            if (count == '0) head <= victim;
          end
          blle_pkg::FN_PUSH_HEAD: begin
            head <= victim;
            if (count == '0) tail <= victim;
          end
          default: if (cur == tail) tail <= victim;
        endcase
      end
      if (cmd.dh_fin) begin
        free_map[head] <= 1'b1;
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          head <= '0; tail <= '0;
        end else head <= l_rd;
      end
      if (cmd.da_fin) begin
        free_map[victim] <= 1'b1;
        count <= count - CW'(1);
        if (victim == tail) tail <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= blle_pkg::func_t'(func);
      r_value <= value;
      r_key <= key;
      r_pos <= position;
      r_removed <= '0;
      r_stat <= blle_pkg::ST_OK;
      idx <= '0;
    end
    if (cmd.set_stat) r_stat <= cmd.stat;
    if (cmd.load) cur <= head;
    if (cmd.step) begin
      cur <= l_rd;
      idx <= idx + CW'(1);
    end
    if (cmd.ins_wr) victim <= newslot;
    if (cmd.da_rd) victim <= l_rd;
    if (cmd.dh_fin) r_removed <= v_rd;
    if (cmd.da_fin) r_removed <= v_rd;
    if (cmd.finish) begin
      status <= r_stat;
      removed_value <= r_removed;
      length <= 5'(count);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(blle_pkg::Capacity)) else $error("count overflow");
  assert property (@(posedge clk) disable iff (rst)
    $countones(~free_map) == int'(count)) else $error("free map disagrees with count");
  assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> free_map[newslot]) else $error("slot not free");
endmodule
